// File: rtl/ctu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctu_pkg
// Shared types, widths and codes of the centroid tracker update core.
// ----------------------------------------------------------------------------
package ctu_pkg;

    // table geometry
    localparam int TABLE_DEPTH   = 32;
    localparam int HISTORY_DEPTH = 8;

    localparam int SLOT_W   = $clog2(TABLE_DEPTH);
    localparam int HPOS_W   = $clog2(HISTORY_DEPTH);
    localparam int HPOS1_W  = HPOS_W + 1;
    localparam int FILL_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int HADDR_W  = $clog2(TABLE_DEPTH * HISTORY_DEPTH);
    localparam int EVC_W    = $clog2(TABLE_DEPTH + 1);

    // fixed field widths
    localparam int CLASS_W    = 8;
    localparam int BOX_W      = 12;
    localparam int AXIS_W     = 14;
    localparam int CENTRE_W   = 2 * AXIS_W;
    localparam int DIST_W     = 13;
    localparam int AGE_W      = 8;
    localparam int LIM_W      = 2 * DIST_W;
    localparam int SQ_W       = 2 * AXIS_W + 1;
    localparam int ROOT_W     = AXIS_W + 1;
    localparam int SUM_W      = ROOT_W + FILL_W;
    localparam int THRN_W     = DIST_W + FILL_W;
    localparam int SLOT_OUT_W = 5;
    localparam int EVC_OUT_W  = 6;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 2;

    localparam logic [AGE_W-1:0] AGE_MAX = '1;
    localparam int MIN_STILL_FILL = 3;

    // entries evicted when a full table takes a new entry
    localparam int EVICT_RAW = (TABLE_DEPTH / 5 > 10) ? TABLE_DEPTH / 5 : 10;
    localparam int EVICT_N   = (EVICT_RAW > TABLE_DEPTH) ? TABLE_DEPTH : EVICT_RAW;
    localparam int PASS_W    = $clog2(EVICT_N + 1);

    // register reset values
    localparam logic [DIST_W-1:0] MATCH_DIST_RST = 13'd200;
    localparam logic [AGE_W-1:0]  STALE_RST      = 8'd30;
    localparam logic [DIST_W-1:0] MOVE_DIST_RST  = 13'd10;
    localparam logic [DIST_W-1:0] STILL_THR_RST  = 13'd4;

    typedef enum logic [1:0] {
        OP_FRAME_BEGIN = 2'd0,
        OP_DETECT      = 2'd1,
        OP_FRAME_END   = 2'd2,
        OP_NONE        = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        EV_ENTERED    = 2'd0,
        EV_MOVED      = 2'd1,
        EV_MATCHED    = 2'd2,
        EV_FRAME_DONE = 2'd3
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MATCH_DIST = 2'd0,
        CFG_STALE      = 2'd1,
        CFG_MOVE_DIST  = 2'd2,
        CFG_STILL_THR  = 2'd3
    } t_cfg_idx;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_AGE,
        CMD_STALE,
        CMD_SCAN_A,
        CMD_SQ,
        CMD_SCAN_C,
        CMD_MV_A,
        CMD_MV_C,
        CMD_HIST_WR,
        CMD_RD0,
        CMD_STILL_CLR,
        CMD_LD0,
        CMD_ST_A,
        CMD_ROOT_GO,
        CMD_ROOT_WAIT,
        CMD_JUDGE,
        CMD_EV_SCAN,
        CMD_EV_KILL,
        CMD_CREATE
    } t_cmd;

    typedef enum logic [4:0] {
        S_IDLE,
        S_AGE,
        S_STALE,
        S_SC_A,
        S_SC_B,
        S_SC_C,
        S_MV_A,
        S_MV_B,
        S_MV_C,
        S_HWR,
        S_RD0,
        S_LD0,
        S_ST_A,
        S_ST_B,
        S_ST_C,
        S_ST_R,
        S_JUDGE,
        S_EV_SCAN,
        S_EV_KILL,
        S_CREATE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic idx_last;
        logic found;
        logic free_ok;
        logic fill_lt3;
        logic root_done;
        logic hist_last;
        logic pass_last;
    } t_stat;

endpackage

// File: rtl/ctu_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctu_isqrt
// Bit-serial floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module ctu_isqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ctu_pkg::SQ_W-1:0]   i_value,
    output logic                       o_done,
    output logic [ctu_pkg::ROOT_W-1:0] o_root
);
    localparam int RW = ctu_pkg::SQ_W + 1;
    localparam logic [RW-1:0] BIT_INIT = RW'(1) << (2 * (ctu_pkg::ROOT_W - 1));

    logic [RW-1:0] r_v;
    logic [RW-1:0] r_r;
    logic [RW-1:0] r_bit;
    logic          r_busy;
    logic          r_done;
    logic [RW-1:0] trial;

    assign trial = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_v    <= RW'(i_value);
                r_r    <= '0;
                r_bit  <= BIT_INIT;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_v >= trial) begin
                    r_v <= r_v - trial;
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit == RW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[ctu_pkg::ROOT_W-1:0];

endmodule

// File: rtl/ctu_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctu_dp
// Tracker datapath: entry table, history memory, distance and root units.
// ----------------------------------------------------------------------------
module ctu_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ctu_pkg::t_cmd                       i_cmd,
    input  logic                                i_cfg_we,
    input  logic [ctu_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ctu_pkg::DIST_W-1:0]          i_cfg_data,
    input  logic [ctu_pkg::CLASS_W-1:0]         i_class_id,
    input  logic [ctu_pkg::BOX_W-1:0]           i_box_x,
    input  logic [ctu_pkg::BOX_W-1:0]           i_box_y,
    input  logic [ctu_pkg::BOX_W-1:0]           i_box_w,
    input  logic [ctu_pkg::BOX_W-1:0]           i_box_h,
    output ctu_pkg::t_stat                      o_stat,
    output logic [ctu_pkg::SLOT_OUT_W-1:0]      o_slot,
    output ctu_pkg::t_event                     o_event_res,
    output logic                                o_stationary,
    output logic [ctu_pkg::AXIS_W-1:0]          o_prev_x,
    output logic [ctu_pkg::AXIS_W-1:0]          o_prev_y,
    output logic [ctu_pkg::EVC_OUT_W-1:0]       o_evicted_count,
    output logic [ctu_pkg::CNT_W-1:0]           o_created_total
);
    localparam int T  = ctu_pkg::TABLE_DEPTH;
    localparam int H  = ctu_pkg::HISTORY_DEPTH;
    localparam int SW = ctu_pkg::SLOT_W;
    localparam int AW = ctu_pkg::AXIS_W;
    localparam int CW = ctu_pkg::CENTRE_W;
    localparam int CNT_W_L = ctu_pkg::CNT_W;

    function automatic logic [ctu_pkg::HPOS_W-1:0] hwrap(
        input logic [ctu_pkg::HPOS1_W-1:0] v
    );
        logic [ctu_pkg::HPOS1_W-1:0] w;
        w = (v >= ctu_pkg::HPOS1_W'(H)) ? v - ctu_pkg::HPOS1_W'(H) : v;
        return w[ctu_pkg::HPOS_W-1:0];
    endfunction

    function automatic logic [ctu_pkg::HADDR_W-1:0] haddr(
        input logic [SW-1:0]                 s,
        input logic [ctu_pkg::HPOS_W-1:0]    p
    );
        return ctu_pkg::HADDR_W'(s) * ctu_pkg::HADDR_W'(H) + ctu_pkg::HADDR_W'(p);
    endfunction

    function automatic logic [AW-1:0] absdiff(input logic [AW-1:0] a, input logic [AW-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // configuration
    logic [ctu_pkg::DIST_W-1:0] r_match_dist, r_move_dist, r_still_thr;
    logic [ctu_pkg::AGE_W-1:0]  r_stale;
    logic [ctu_pkg::LIM_W-1:0]  r_lim, r_mv_lim;

    // entry table
    logic                         r_valid [T];
    logic [ctu_pkg::AGE_W-1:0]    r_age   [T];
    logic [ctu_pkg::CLASS_W-1:0]  r_class [T];
    logic [CW-1:0]                r_centre[T];
    logic [ctu_pkg::FILL_W-1:0]   r_fill  [T];
    logic [ctu_pkg::HPOS_W-1:0]   r_head  [T];

    // history memory
    logic [CW-1:0]                r_hist [T*H];
    logic [CW-1:0]                r_hist_q;
    logic                         hist_we, hist_re;
    logic [ctu_pkg::HADDR_W-1:0]  hist_waddr, hist_raddr;
    logic [CW-1:0]                hist_wdata;
    logic [ctu_pkg::HPOS_W-1:0]   rd_log, wr_pos;

    // item and scan state
    logic [ctu_pkg::CLASS_W-1:0]  r_cls;
    logic [CW-1:0]                r_c;
    logic [SW-1:0]                r_idx, r_best, r_free, r_pick, new_slot;
    logic [ctu_pkg::SQ_W-1:0]     r_bestd, r_sq;
    logic                         r_found, r_free_ok, r_have, r_moved;
    logic [ctu_pkg::AGE_W-1:0]    r_age_best;
    logic [ctu_pkg::PASS_W-1:0]   r_pass;
    logic [ctu_pkg::EVC_W-1:0]    r_evicted;
    logic [CNT_W_L-1:0]           r_created;

    // distance and stationary units
    logic [AW-1:0]                r_dx, r_dy;
    logic [CW-1:0]                pa, pb, r_pb;
    logic [ctu_pkg::FILL_W-1:0]   r_j;
    logic [ctu_pkg::SUM_W-1:0]    r_sum;
    logic [ctu_pkg::THRN_W-1:0]   r_thr_n;
    logic                         root_done;
    logic [ctu_pkg::ROOT_W-1:0]   root;

    // results
    logic [SW-1:0]                r_res_slot;
    ctu_pkg::t_event              r_res_ev;
    logic                         r_res_still;
    logic [CW-1:0]                r_res_prev;

    logic idx_last;
    logic [SW-1:0] idx_next;
    logic scan_hit, scan_free;

    assign idx_last = (r_idx == SW'(T - 1));
    assign idx_next = idx_last ? '0 : r_idx + SW'(1);
    assign new_slot = r_free_ok ? r_free : SW'(T - 1);

    // match and free-slot tests on the entry under scan
    assign scan_hit  = r_valid[r_idx] && r_class[r_idx] == r_cls
                    && r_sq < ctu_pkg::SQ_W'(r_lim) && (!r_found || r_sq < r_bestd);
    assign scan_free = !r_valid[r_idx];

    ctu_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd == ctu_pkg::CMD_ROOT_GO),
        .i_value (r_sq),
        .o_done  (root_done),
        .o_root  (root)
    );

    // operand select for the absolute difference step
    always_comb begin
        case (i_cmd)
            ctu_pkg::CMD_MV_A: begin
                pa = r_centre[r_best];
                pb = r_c;
            end
            ctu_pkg::CMD_ST_A: begin
                pa = r_hist_q;
                pb = r_pb;
            end
            default: begin
                pa = r_centre[r_idx];
                pb = r_c;
            end
        endcase
    end

    // history memory addressing
    always_comb begin
        if (r_fill[r_best] < ctu_pkg::FILL_W'(H)) begin
            wr_pos = hwrap(ctu_pkg::HPOS1_W'(r_head[r_best])
                         + ctu_pkg::HPOS1_W'(r_fill[r_best]));
        end else begin
            wr_pos = r_head[r_best];
        end
        hist_we    = (i_cmd == ctu_pkg::CMD_HIST_WR) || (i_cmd == ctu_pkg::CMD_CREATE);
        hist_waddr = (i_cmd == ctu_pkg::CMD_CREATE) ? haddr(new_slot, '0)
                                                    : haddr(r_best, wr_pos);
        hist_wdata = (i_cmd == ctu_pkg::CMD_CREATE) ? r_c : r_centre[r_best];
        case (i_cmd)
            ctu_pkg::CMD_RD0: rd_log = '0;
            ctu_pkg::CMD_LD0: rd_log = ctu_pkg::HPOS_W'(1);
            default:          rd_log = ctu_pkg::HPOS_W'(r_j + ctu_pkg::FILL_W'(1));
        endcase
        hist_re = (i_cmd == ctu_pkg::CMD_RD0) || (i_cmd == ctu_pkg::CMD_LD0)
               || ((i_cmd == ctu_pkg::CMD_ROOT_WAIT) && root_done && !o_stat.hist_last);
        hist_raddr = haddr(r_best, hwrap(ctu_pkg::HPOS1_W'(r_head[r_best])
                                       + ctu_pkg::HPOS1_W'(rd_log)));
    end

    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            r_hist[hist_waddr] <= hist_wdata;
        end
        if (hist_re) begin
            r_hist_q <= r_hist[hist_raddr];
        end
    end

    // configuration registers and squared limits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_dist <= ctu_pkg::MATCH_DIST_RST;
            r_stale      <= ctu_pkg::STALE_RST;
            r_move_dist  <= ctu_pkg::MOVE_DIST_RST;
            r_still_thr  <= ctu_pkg::STILL_THR_RST;
        end else if (i_cfg_we) begin
            case (ctu_pkg::t_cfg_idx'(i_cfg_idx))
                ctu_pkg::CFG_MATCH_DIST: r_match_dist <= i_cfg_data;
                ctu_pkg::CFG_STALE:      r_stale      <= i_cfg_data[ctu_pkg::AGE_W-1:0];
                ctu_pkg::CFG_MOVE_DIST:  r_move_dist  <= i_cfg_data;
                ctu_pkg::CFG_STILL_THR:  r_still_thr  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_lim    <= ctu_pkg::LIM_W'(r_match_dist) * ctu_pkg::LIM_W'(r_match_dist);
        r_mv_lim <= ctu_pkg::LIM_W'(r_move_dist) * ctu_pkg::LIM_W'(r_move_dist);
    end

    // control state of the table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < T; i++) begin
                r_valid[i] <= 1'b0;
            end
            r_created <= '0;
            r_idx     <= '0;
            r_found   <= 1'b0;
            r_free_ok <= 1'b0;
            r_have    <= 1'b0;
            r_pass    <= '0;
            r_evicted <= '0;
        end else begin
            case (i_cmd)
                ctu_pkg::CMD_LOAD: begin
                    r_idx     <= '0;
                    r_found   <= 1'b0;
                    r_free_ok <= 1'b0;
                    r_have    <= 1'b0;
                    r_pass    <= '0;
                    r_evicted <= '0;
                end
                ctu_pkg::CMD_AGE: begin
                    for (int i = 0; i < T; i++) begin
                        if (r_valid[i] && r_age[i] != ctu_pkg::AGE_MAX) begin
                            r_age[i] <= r_age[i] + ctu_pkg::AGE_W'(1);
                        end
                    end
                end
                ctu_pkg::CMD_STALE: begin
                    if (r_valid[r_idx] && r_age[r_idx] > r_stale) begin
                        r_valid[r_idx] <= 1'b0;
                        r_evicted      <= r_evicted + ctu_pkg::EVC_W'(1);
                    end
                    r_idx <= idx_next;
                end
                ctu_pkg::CMD_SCAN_C: begin
                    if (scan_hit) begin
                        r_found <= 1'b1;
                        r_best  <= r_idx;
                        r_bestd <= r_sq;
                    end
                    if (scan_free && !r_free_ok) begin
                        r_free_ok <= 1'b1;
                        r_free    <= r_idx;
                    end
                    r_idx <= idx_next;
                end
                ctu_pkg::CMD_HIST_WR: begin
                    if (r_fill[r_best] < ctu_pkg::FILL_W'(H)) begin
                        r_fill[r_best] <= r_fill[r_best] + ctu_pkg::FILL_W'(1);
                    end else begin
                        r_head[r_best] <= hwrap(ctu_pkg::HPOS1_W'(r_head[r_best])
                                              + ctu_pkg::HPOS1_W'(1));
                    end
                    r_centre[r_best] <= r_c;
                    r_age[r_best]    <= '0;
                end
                ctu_pkg::CMD_EV_SCAN: begin
                    if (r_valid[r_idx] && (!r_have || r_age[r_idx] > r_age_best)) begin
                        r_have     <= 1'b1;
                        r_pick     <= r_idx;
                        r_age_best <= r_age[r_idx];
                    end
                    r_idx <= idx_next;
                end
                ctu_pkg::CMD_EV_KILL: begin
                    r_valid[r_pick] <= 1'b0;
                    r_evicted       <= r_evicted + ctu_pkg::EVC_W'(1);
                    r_pass          <= r_pass + ctu_pkg::PASS_W'(1);
                    r_have          <= 1'b0;
                    if (!r_free_ok || r_pick < r_free) begin
                        r_free_ok <= 1'b1;
                        r_free    <= r_pick;
                    end
                end
                ctu_pkg::CMD_CREATE: begin
                    r_valid[new_slot]  <= 1'b1;
                    r_class[new_slot]  <= r_cls;
                    r_centre[new_slot] <= r_c;
                    r_age[new_slot]    <= '0;
                    r_fill[new_slot]   <= ctu_pkg::FILL_W'(1);
                    r_head[new_slot]   <= '0;
                    r_created          <= r_created + CNT_W_L'(1);
                end
                default: ;
            endcase
        end
    end

    // item payload, distance, stationary and result registers
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            ctu_pkg::CMD_LOAD: begin
                r_cls <= i_class_id;
                r_c   <= {AW'({i_box_x, 1'b0}) + AW'(i_box_w),
                          AW'({i_box_y, 1'b0}) + AW'(i_box_h)};
                r_res_slot  <= '0;
                r_res_ev    <= ctu_pkg::EV_FRAME_DONE;
                r_res_still <= 1'b0;
                r_res_prev  <= '0;
            end
            ctu_pkg::CMD_SCAN_A, ctu_pkg::CMD_MV_A, ctu_pkg::CMD_ST_A: begin
                r_dx <= absdiff(pa[CW-1:AW], pb[CW-1:AW]);
                r_dy <= absdiff(pa[AW-1:0], pb[AW-1:0]);
                if (i_cmd == ctu_pkg::CMD_ST_A) begin
                    r_pb <= r_hist_q;
                end
            end
            ctu_pkg::CMD_SQ: begin
                r_sq <= ctu_pkg::SQ_W'(r_dx) * ctu_pkg::SQ_W'(r_dx)
                      + ctu_pkg::SQ_W'(r_dy) * ctu_pkg::SQ_W'(r_dy);
            end
            ctu_pkg::CMD_MV_C: begin
                r_moved    <= r_sq > ctu_pkg::SQ_W'(r_mv_lim);
                r_res_prev <= r_centre[r_best];
            end
            ctu_pkg::CMD_HIST_WR: begin
                r_res_slot <= r_best;
                r_res_ev   <= r_moved ? ctu_pkg::EV_MOVED : ctu_pkg::EV_MATCHED;
            end
            ctu_pkg::CMD_RD0: begin
                r_sum   <= '0;
                r_thr_n <= ctu_pkg::THRN_W'(r_still_thr)
                         * ctu_pkg::THRN_W'(r_fill[r_best] - ctu_pkg::FILL_W'(1));
            end
            ctu_pkg::CMD_STILL_CLR: begin
                r_res_still <= 1'b0;
            end
            ctu_pkg::CMD_LD0: begin
                r_pb <= r_hist_q;
                r_j  <= ctu_pkg::FILL_W'(1);
            end
            ctu_pkg::CMD_ROOT_WAIT: begin
                if (root_done) begin
                    r_sum <= r_sum + ctu_pkg::SUM_W'(root);
                    r_j   <= r_j + ctu_pkg::FILL_W'(1);
                end
            end
            ctu_pkg::CMD_JUDGE: begin
                r_res_still <= r_sum <= ctu_pkg::SUM_W'(r_thr_n);
            end
            ctu_pkg::CMD_CREATE: begin
                r_res_slot  <= new_slot;
                r_res_ev    <= ctu_pkg::EV_ENTERED;
                r_res_still <= 1'b0;
                r_res_prev  <= r_c;
            end
            default: ;
        endcase
    end

    // found and free include the entry scanned in the current cycle
    always_comb begin
        o_stat.idx_last  = idx_last;
        o_stat.found     = r_found || ((i_cmd == ctu_pkg::CMD_SCAN_C) && scan_hit);
        o_stat.free_ok   = r_free_ok || ((i_cmd == ctu_pkg::CMD_SCAN_C) && scan_free);
        o_stat.fill_lt3  = r_fill[r_best] < ctu_pkg::FILL_W'(ctu_pkg::MIN_STILL_FILL);
        o_stat.root_done = root_done;
        o_stat.hist_last = (r_j == r_fill[r_best] - ctu_pkg::FILL_W'(1));
        o_stat.pass_last = (r_pass == ctu_pkg::PASS_W'(ctu_pkg::EVICT_N - 1));
    end

    assign o_slot          = ctu_pkg::SLOT_OUT_W'(r_res_slot);
    assign o_event_res     = r_res_ev;
    assign o_stationary    = r_res_still;
    assign o_prev_x        = r_res_prev[CW-1:AW];
    assign o_prev_y        = r_res_prev[AW-1:0];
    assign o_evicted_count = ctu_pkg::EVC_OUT_W'(r_evicted);
    assign o_created_total = r_created;

endmodule

// File: rtl/ctu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctu_ctrl
// Sequencer of the tracker: walks the datapath through each transaction.
// ----------------------------------------------------------------------------
module ctu_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  ctu_pkg::t_op    i_op,
    input  ctu_pkg::t_stat  i_stat,
    output ctu_pkg::t_cmd   o_cmd,
    output logic            o_busy,
    output logic            o_done
);
    ctu_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ctu_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = ctu_pkg::CMD_NONE;
        case (r_state)
            ctu_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd = ctu_pkg::CMD_LOAD;
                    case (i_op)
                        ctu_pkg::OP_FRAME_BEGIN: n_state = ctu_pkg::S_AGE;
                        ctu_pkg::OP_DETECT:      n_state = ctu_pkg::S_SC_A;
                        ctu_pkg::OP_FRAME_END:   n_state = ctu_pkg::S_STALE;
                        default:                 n_state = ctu_pkg::S_DONE;
                    endcase
                end
            end
            ctu_pkg::S_AGE: begin
                o_cmd   = ctu_pkg::CMD_AGE;
                n_state = ctu_pkg::S_DONE;
            end
            ctu_pkg::S_STALE: begin
                o_cmd = ctu_pkg::CMD_STALE;
                if (i_stat.idx_last) n_state = ctu_pkg::S_DONE;
            end
            ctu_pkg::S_SC_A: begin
                o_cmd   = ctu_pkg::CMD_SCAN_A;
                n_state = ctu_pkg::S_SC_B;
            end
            ctu_pkg::S_SC_B: begin
                o_cmd   = ctu_pkg::CMD_SQ;
                n_state = ctu_pkg::S_SC_C;
            end
            ctu_pkg::S_SC_C: begin
                o_cmd = ctu_pkg::CMD_SCAN_C;
                if (!i_stat.idx_last) begin
                    n_state = ctu_pkg::S_SC_A;
                end else if (i_stat.found) begin
                    n_state = ctu_pkg::S_MV_A;
                end else if (i_stat.free_ok) begin
                    n_state = ctu_pkg::S_CREATE;
                end else begin
                    n_state = ctu_pkg::S_EV_SCAN;
                end
            end
            ctu_pkg::S_MV_A: begin
                o_cmd   = ctu_pkg::CMD_MV_A;
                n_state = ctu_pkg::S_MV_B;
            end
            ctu_pkg::S_MV_B: begin
                o_cmd   = ctu_pkg::CMD_SQ;
                n_state = ctu_pkg::S_MV_C;
            end
            ctu_pkg::S_MV_C: begin
                o_cmd   = ctu_pkg::CMD_MV_C;
                n_state = ctu_pkg::S_HWR;
            end
            ctu_pkg::S_HWR: begin
                o_cmd   = ctu_pkg::CMD_HIST_WR;
                n_state = ctu_pkg::S_RD0;
            end
            ctu_pkg::S_RD0: begin
                if (i_stat.fill_lt3) begin
                    o_cmd   = ctu_pkg::CMD_STILL_CLR;
                    n_state = ctu_pkg::S_DONE;
                end else begin
                    o_cmd   = ctu_pkg::CMD_RD0;
                    n_state = ctu_pkg::S_LD0;
                end
            end
            ctu_pkg::S_LD0: begin
                o_cmd   = ctu_pkg::CMD_LD0;
                n_state = ctu_pkg::S_ST_A;
            end
            ctu_pkg::S_ST_A: begin
                o_cmd   = ctu_pkg::CMD_ST_A;
                n_state = ctu_pkg::S_ST_B;
            end
            ctu_pkg::S_ST_B: begin
                o_cmd   = ctu_pkg::CMD_SQ;
                n_state = ctu_pkg::S_ST_C;
            end
            ctu_pkg::S_ST_C: begin
                o_cmd   = ctu_pkg::CMD_ROOT_GO;
                n_state = ctu_pkg::S_ST_R;
            end
            ctu_pkg::S_ST_R: begin
                o_cmd = ctu_pkg::CMD_ROOT_WAIT;
                if (i_stat.root_done) begin
                    n_state = i_stat.hist_last ? ctu_pkg::S_JUDGE : ctu_pkg::S_ST_A;
                end
            end
            ctu_pkg::S_JUDGE: begin
                o_cmd   = ctu_pkg::CMD_JUDGE;
                n_state = ctu_pkg::S_DONE;
            end
            ctu_pkg::S_EV_SCAN: begin
                o_cmd = ctu_pkg::CMD_EV_SCAN;
                if (i_stat.idx_last) n_state = ctu_pkg::S_EV_KILL;
            end
            ctu_pkg::S_EV_KILL: begin
                o_cmd   = ctu_pkg::CMD_EV_KILL;
                n_state = i_stat.pass_last ? ctu_pkg::S_CREATE : ctu_pkg::S_EV_SCAN;
            end
            ctu_pkg::S_CREATE: begin
                o_cmd   = ctu_pkg::CMD_CREATE;
                n_state = ctu_pkg::S_DONE;
            end
            ctu_pkg::S_DONE: begin
                n_state = ctu_pkg::S_IDLE;
            end
            default: begin
                n_state = ctu_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ctu_pkg::S_IDLE);
    assign o_done = (r_state == ctu_pkg::S_DONE);

endmodule

// File: rtl/centroid_tracker_update_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// centroid_tracker_update_core
// Nearest-neighbour centroid tracker table: frame aging, detection matching
// with movement and stationary judgement, table eviction.
// ----------------------------------------------------------------------------
//
//  channel   signals                              transfer
//  --------  -----------------------------------  ------------------------------
//  command   start, busy, i_opcode .. i_box_h     start && !busy at clock edge
//  result    o_valid, o_slot .. o_created_total   o_valid high for one cycle
//  config    i_cfg_we, i_cfg_idx, i_cfg_data      i_cfg_we at clock edge
//
// One transaction at a time; busy stays high until its result strobe.
// Frame begin ages every entry at once; frame end checks one entry at a time.
// A detection scans the table entry by entry; a match then measures movement
// and walks the history with a square and a bit-serial root per step; a new
// entry into a full table adds 10 eviction scans of the table.
// Reset is synchronous; results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module centroid_tracker_update_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_opcode,
    input  logic [ctu_pkg::CLASS_W-1:0]         i_class_id,
    input  logic [ctu_pkg::BOX_W-1:0]           i_box_x,
    input  logic [ctu_pkg::BOX_W-1:0]           i_box_y,
    input  logic [ctu_pkg::BOX_W-1:0]           i_box_w,
    input  logic [ctu_pkg::BOX_W-1:0]           i_box_h,
    input  logic                                i_cfg_we,
    input  logic [ctu_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ctu_pkg::DIST_W-1:0]          i_cfg_data,
    output logic                                o_valid,
    output logic [ctu_pkg::SLOT_OUT_W-1:0]      o_slot,
    output logic [1:0]                          o_event_res,
    output logic                                o_stationary,
    output logic [ctu_pkg::AXIS_W-1:0]          o_prev_x,
    output logic [ctu_pkg::AXIS_W-1:0]          o_prev_y,
    output logic [ctu_pkg::EVC_OUT_W-1:0]       o_evicted_count,
    output logic [ctu_pkg::CNT_W-1:0]           o_created_total
);
    ctu_pkg::t_cmd   cmd;
    ctu_pkg::t_stat  stat;
    ctu_pkg::t_event ev;

    // sequencer: one state per datapath step
    ctu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (ctu_pkg::t_op'(i_opcode)),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_valid)
    );

    // table, history memory and arithmetic; result fields held until next item
    ctu_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_class_id      (i_class_id),
        .i_box_x         (i_box_x),
        .i_box_y         (i_box_y),
        .i_box_w         (i_box_w),
        .i_box_h         (i_box_h),
        .o_stat          (stat),
        .o_slot          (o_slot),
        .o_event_res     (ev),
        .o_stationary    (o_stationary),
        .o_prev_x        (o_prev_x),
        .o_prev_y        (o_prev_y),
        .o_evicted_count (o_evicted_count),
        .o_created_total (o_created_total)
    );

    assign o_event_res = ev;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the centroid tracker update core. A behavioral
// copy of the tracker table predicts each result; directed and random command
// streams cover aging, matching, movement, stationary judgement and eviction.
// ----------------------------------------------------------------------------
module testbench;

    localparam int N_SLOT  = 32;
    localparam int N_HIST  = 8;
    localparam int WD_MAX  = 20000;
    localparam int N_EXP   = 1024;

    typedef struct packed {
        logic [4:0]  slot;
        logic [1:0]  ev;
        logic        still;
        logic [13:0] px;
        logic [13:0] py;
        logic [5:0]  evc;
        logic [31:0] created;
    } t_track_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_opcode = '0;
    logic [7:0]  i_class_id = '0;
    logic [11:0] i_box_x = '0, i_box_y = '0, i_box_w = '0, i_box_h = '0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [12:0] i_cfg_data = '0;
    logic        o_valid;
    logic [4:0]  o_slot;
    logic [1:0]  o_event_res;
    logic        o_stationary;
    logic [13:0] o_prev_x, o_prev_y;
    logic [5:0]  o_evicted_count;
    logic [31:0] o_created_total;

    centroid_tracker_update_core dut (.*);

    initial forever #4 i_clk = ~i_clk;

    // tracker shadow state
    logic [12:0] match_dist, move_dist, still_thr;
    logic [7:0]  stale_lim;
    logic        tv [N_SLOT];
    logic [7:0]  tcls [N_SLOT];
    logic [27:0] tctr [N_SLOT];
    logic [7:0]  tage [N_SLOT];
    logic        tstill [N_SLOT];
    logic [27:0] thist [N_SLOT][N_HIST];
    int          tfill [N_SLOT];
    logic [31:0] created_cnt;

    // expected results, written when busy falls after a command and read at the result strobe
    t_track_res exp_mem [N_EXP];
    int exp_wr = 0;
    int exp_rd = 0;
    int errors = 0;
    int watchdog = 0;
    logic timed_out = 1'b0;

    function automatic int unsigned isqrt(int unsigned v);
        int unsigned r;
        r = 0;
        for (int b = 15; b >= 0; b--)
            if ((r | (1 << b)) * (r | (1 << b)) <= v) r |= (1 << b);
        return r;
    endfunction

    function automatic int unsigned dist2(logic [27:0] a, logic [27:0] b);
        int dx, dy;
        dx = int'(a[27:14]) - int'(b[27:14]);
        dy = int'(a[13:0]) - int'(b[13:0]);
        return dx * dx + dy * dy;
    endfunction

    function automatic void reset_tracker();
        match_dist = ctu_pkg::MATCH_DIST_RST; stale_lim = ctu_pkg::STALE_RST;
        move_dist = ctu_pkg::MOVE_DIST_RST;   still_thr = ctu_pkg::STILL_THR_RST;
        for (int i = 0; i < N_SLOT; i++) begin
            tv[i] = 0; tfill[i] = 0;
        end
        created_cnt = 0;
    endfunction

    // computes the result of one command and updates the shadow table
    function automatic t_track_res track_update(logic [1:0] op, logic [7:0] cls,
            logic [11:0] bx, logic [11:0] by, logic [11:0] bw, logic [11:0] bh);
        t_track_res r;
        logic [27:0] c, old;
        int best, cnt, s, k, sum;
        int unsigned bestd, d;
        r = '0;
        r.ev = ctu_pkg::EV_FRAME_DONE;
        if (op == ctu_pkg::OP_FRAME_BEGIN) begin
            for (int i = 0; i < N_SLOT; i++)
                if (tv[i] && tage[i] != 8'hff) tage[i]++;
        end else if (op == ctu_pkg::OP_FRAME_END) begin
            for (int i = 0; i < N_SLOT; i++)
                if (tv[i] && tage[i] > stale_lim) begin
                    tv[i] = 0; r.evc++;
                end
        end else if (op == ctu_pkg::OP_DETECT) begin
            c[27:14] = 14'(2 * bx + bw);
            c[13:0]  = 14'(2 * by + bh);
            best = -1; bestd = 0;
            for (int i = 0; i < N_SLOT; i++)
                if (tv[i] && tcls[i] == cls) begin
                    d = dist2(tctr[i], c);
                    if (d < match_dist * match_dist && (best < 0 || d < bestd)) begin
                        best = i; bestd = d;
                    end
                end
            if (best >= 0) begin
                old = tctr[best];
                if (tfill[best] >= N_HIST) begin
                    for (int j = 0; j < N_HIST - 1; j++) thist[best][j] = thist[best][j+1];
                    tfill[best] = N_HIST - 1;
                end
                thist[best][tfill[best]] = old;
                tfill[best]++;
                tctr[best] = c; tage[best] = 0;
                if (tfill[best] < 3) tstill[best] = 0;
                else begin
                    sum = 0;
                    for (int j = 1; j < tfill[best]; j++)
                        sum += isqrt(dist2(thist[best][j], thist[best][j-1]));
                    tstill[best] = sum <= still_thr * (tfill[best] - 1);
                end
                r.slot = best; r.still = tstill[best];
                {r.px, r.py} = old;
                r.ev = dist2(c, old) > move_dist * move_dist ? ctu_pkg::EV_MOVED
                                                             : ctu_pkg::EV_MATCHED;
            end else begin
                cnt = 0;
                for (int i = 0; i < N_SLOT; i++) cnt += tv[i];
                if (cnt >= N_SLOT)
                    for (k = 0; k < ctu_pkg::EVICT_N; k++) begin
                        best = -1;
                        for (int i = 0; i < N_SLOT; i++)
                            if (tv[i] && (best < 0 || tage[i] > tage[best])) best = i;
                        if (best >= 0) begin
                            tv[best] = 0; r.evc++;
                        end
                    end
                s = 0;
                while (s < N_SLOT - 1 && tv[s]) s++;
                tv[s] = 1; tcls[s] = cls; tctr[s] = c; tage[s] = 0; tstill[s] = 0;
                thist[s][0] = c; tfill[s] = 1;
                created_cnt++;
                r.slot = s; {r.px, r.py} = c; r.ev = ctu_pkg::EV_ENTERED;
            end
        end
        r.created = created_cnt;
        return r;
    endfunction

    function automatic void report_mismatch(string what, longint got, longint exp_v);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_v, $realtime);
        errors++;
    endfunction

    // result checker: the receiver cannot stall, so every strobe is taken
    always @(posedge i_clk) begin
        t_track_res e;
        if (i_rst_n && o_valid) begin
            if (exp_rd == exp_wr) report_mismatch("unexpected transaction", 1, 0);
            else begin
                e = exp_mem[exp_rd % N_EXP];
                exp_rd++;
                if (o_slot !== e.slot) report_mismatch("slot", o_slot, e.slot);
                if (o_event_res !== e.ev) report_mismatch("event", o_event_res, e.ev);
                if (o_stationary !== e.still)
                    report_mismatch("stationary", o_stationary, e.still);
                if (o_prev_x !== e.px) report_mismatch("prev_x", o_prev_x, e.px);
                if (o_prev_y !== e.py) report_mismatch("prev_y", o_prev_y, e.py);
                if (o_evicted_count !== e.evc)
                    report_mismatch("evicted", o_evicted_count, e.evc);
                if (o_created_total !== e.created)
                    report_mismatch("created", o_created_total, e.created);
            end
        end
    end

    // watchdog on cycles with no accepted transaction of either kind
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) watchdog <= 0;
        else watchdog <= watchdog + 1;
        if (watchdog >= WD_MAX && !timed_out) begin
            timed_out <= 1'b1;
            $display("testbench failed");
            $finish;
        end
    end

    // sender burst pacing
    int burst_left = 0;

    task automatic send_cmd(logic [1:0] op, logic [7:0] cls,
            logic [11:0] bx, logic [11:0] by, logic [11:0] bw, logic [11:0] bh);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
        burst_left--;
        start <= 1'b1; i_opcode <= op; i_class_id <= cls;
        i_box_x <= bx; i_box_y <= by; i_box_w <= bw; i_box_h <= bh;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        exp_mem[exp_wr % N_EXP] = track_update(op, cls, bx, by, bw, bh);
        exp_wr++;
        start <= 1'b0;
        // busy is high in this cycle anyway
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (exp_rd != exp_wr) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // only called when idle
    task automatic write_reg(ctu_pkg::t_cfg_idx idx, logic [12:0] val);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            ctu_pkg::CFG_MATCH_DIST: match_dist = val;
            ctu_pkg::CFG_STALE:      stale_lim = val[7:0];
            ctu_pkg::CFG_MOVE_DIST:  move_dist = val;
            ctu_pkg::CFG_STILL_THR:  still_thr = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_cmd(ctu_pkg::OP_FRAME_BEGIN, 0, 0, 0, 0, 0);
        send_cmd(ctu_pkg::OP_DETECT, 8'h00, 12'h000, 12'h000, 12'h000, 12'h000);
        send_cmd(ctu_pkg::OP_DETECT, 8'hff, 12'hfff, 12'hfff, 12'hfff, 12'hfff);
        send_cmd(ctu_pkg::OP_DETECT, 8'hff, 12'hffd, 12'hfff, 12'hfff, 12'hfff);  // small shift
        send_cmd(ctu_pkg::OP_DETECT, 8'hff, 12'hfe0, 12'hfff, 12'hfff, 12'hfff);  // moved
        send_cmd(ctu_pkg::OP_DETECT, 8'hff, 12'hfe0, 12'hfff, 12'hfff, 12'hfff);  // same position again
        send_cmd(ctu_pkg::OP_DETECT, 8'h00, 12'h800, 12'h800, 12'h000, 12'h000);  // too far
        send_cmd(ctu_pkg::OP_DETECT, 8'h01, 12'h000, 12'h000, 12'h000, 12'h000);  // other class
        send_cmd(ctu_pkg::OP_NONE, 8'h55, 12'h123, 12'h456, 12'h789, 12'habc);
        send_cmd(ctu_pkg::OP_FRAME_BEGIN, 0, 0, 0, 0, 0);
        send_cmd(ctu_pkg::OP_FRAME_END, 0, 0, 0, 0, 0);
        // three nearby detections of one class all update the same entry
        send_cmd(ctu_pkg::OP_DETECT, 8'h07, 12'd100, 12'd100, 0, 0);
        send_cmd(ctu_pkg::OP_DETECT, 8'h07, 12'd120, 12'd100, 0, 0);
        send_cmd(ctu_pkg::OP_DETECT, 8'h07, 12'd110, 12'd100, 0, 0);
        drain();
    endtask

    task automatic test_stale_evict();
        write_reg(ctu_pkg::CFG_STALE, 13'd0);
        send_cmd(ctu_pkg::OP_FRAME_BEGIN, 0, 0, 0, 0, 0);
        send_cmd(ctu_pkg::OP_FRAME_END, 0, 0, 0, 0, 0);
        drain();
        write_reg(ctu_pkg::CFG_STALE, 13'd255);
        // one live entry whose age saturates
        send_cmd(ctu_pkg::OP_DETECT, 8'h09, 12'd5, 12'd5, 0, 0);
        for (int i = 0; i < 260; i++) send_cmd(ctu_pkg::OP_FRAME_BEGIN, 0, 0, 0, 0, 0);
        send_cmd(ctu_pkg::OP_FRAME_END, 0, 0, 0, 0, 0);
        drain();
    endtask

    task automatic test_full_table();
        write_reg(ctu_pkg::CFG_MATCH_DIST, 13'd0);  // nothing matches
        for (int i = 0; i < 40; i++) begin
            if (i % 5 == 0) send_cmd(ctu_pkg::OP_FRAME_BEGIN, 0, 0, 0, 0, 0);
            send_cmd(ctu_pkg::OP_DETECT, 8'($urandom), 12'($urandom), 12'($urandom),
                     12'($urandom), 12'($urandom));
        end
        drain();  // sender pauses until every expected result has come
        write_reg(ctu_pkg::CFG_STALE, 13'd2);
        send_cmd(ctu_pkg::OP_FRAME_END, 0, 0, 0, 0, 0);
        drain();
    endtask

    // tracks of a few objects wandering with random steps
    task automatic test_random_tracks(int n_items, logic [12:0] mdist,
            logic [12:0] mvdist, logic [12:0] sthr, logic [7:0] stale);
        int ox [8], oy [8];
        int k, r;
        write_reg(ctu_pkg::CFG_MATCH_DIST, mdist);
        write_reg(ctu_pkg::CFG_MOVE_DIST, mvdist);
        write_reg(ctu_pkg::CFG_STILL_THR, sthr);
        write_reg(ctu_pkg::CFG_STALE, {5'd0, stale});
        for (int j = 0; j < 8; j++) begin
            ox[j] = $urandom_range(0, 4095); oy[j] = $urandom_range(0, 4095);
        end
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8) send_cmd(ctu_pkg::OP_FRAME_BEGIN, 8'($urandom), 0, 0, 0, 0);
            else if (r < 12) send_cmd(ctu_pkg::OP_FRAME_END, 8'($urandom), 0, 0, 0, 0);
            else if (r < 14) send_cmd(ctu_pkg::OP_NONE, 8'($urandom), 12'($urandom), 0, 0, 0);
            else if (r < 24)
                send_cmd(ctu_pkg::OP_DETECT, 8'($urandom), 12'($urandom), 12'($urandom),
                         12'($urandom), 12'($urandom));
            else begin
                k = $urandom_range(0, 7);
                ox[k] = (ox[k] + $urandom_range(0, 12) - 6) & 12'hfff;
                oy[k] = (oy[k] + $urandom_range(0, 12) - 6) & 12'hfff;
                send_cmd(ctu_pkg::OP_DETECT, 8'(k % 3), 12'(ox[k]), 12'(oy[k]),
                         12'd40, 12'd30);
            end
        end
        drain();
    endtask

    initial begin
        reset_tracker();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_stale_evict();
        test_full_table();
        test_random_tracks(220, ctu_pkg::MATCH_DIST_RST, ctu_pkg::MOVE_DIST_RST,
                           ctu_pkg::STILL_THR_RST, ctu_pkg::STALE_RST);
        test_random_tracks(110, 13'h1fff, 13'd0, 13'd0, 8'd3);
        test_random_tracks(110, 13'd12, 13'h1fff, 13'h1fff, 8'd1);
        test_random_tracks(80, 13'd30, 13'd4, 13'd6, 8'd0);
        if (errors == 0 && !timed_out) $display("testbench passed");
        else $display("testbench failed");
        $finish;
    end

endmodule
